>>> rtl/core/text_console_cursor_escape_unit_assert.svh
// Assertion macros for the text console cursor and escape unit.
// Both macros sample on aclk and stay quiet while aresetn is low.
`ifndef TEXT_CONSOLE_CURSOR_ESCAPE_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ESCAPE_UNIT_ASSERT_SVH

// Check that a condition holds at every clock edge.
`define TCCE_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("tcce invariant violated");

// Check that a consequent holds whenever an antecedent holds.
`define TCCE_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tcce implication violated");

`endif

>>> rtl/core/tcce_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types, character codes and helpers for the text console cursor and
// escape unit.
// ----------------------------------------------------------------------------
package tcce_pkg;

    // Character codes recognized by the parser
    localparam logic [7:0] CHAR_LF       = 8'h0a;
    localparam logic [7:0] CHAR_CR       = 8'h0d;
    localparam logic [7:0] CHAR_ESC      = 8'h1b;
    localparam logic [7:0] CHAR_D        = 8'h44;
    localparam logic [7:0] CHAR_LBRACKET = 8'h5b;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [31:0] DEC_BASE     = 32'd10;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 9;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_COLUMNS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ROWS    = 8'd1;

    // Register reset values
    localparam logic [8:0] COLUMNS_RESET = 9'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd30;

    // Screen size limits: parameter defaults and field-width ceilings
    localparam int DEF_MAX_COLUMNS = 256;
    localparam int DEF_MAX_ROWS    = 128;
    localparam int HW_COL_LIMIT    = 256;
    localparam int HW_ROW_LIMIT    = 128;

    // Parser and cursor state
    typedef struct packed {
        logic        in_escape;
        logic [31:0] escape_number;
        logic [7:0]  cursor_column;
        logic [6:0]  cursor_row;
    } tcce_state_t;

    // One result item
    typedef struct packed {
        logic       draw_valid;
        logic [7:0] glyph_code;
        logic [7:0] draw_column;
        logic [6:0] draw_row;
        logic       scroll_up;
    } tcce_result_t;

    // Effective column count: zero counts as one, clamp to the limit
    function automatic logic [8:0] eff_columns(input logic [8:0] raw, input logic [8:0] lim);
        logic [8:0] c;
        c = (raw == 9'd0) ? 9'd1 : raw;
        if (c > lim) c = lim;
        return c;
    endfunction

    // Effective row count: zero counts as one, clamp to the limit
    function automatic logic [7:0] eff_rows(input logic [7:0] raw, input logic [7:0] lim);
        logic [7:0] r;
        r = (raw == 8'd0) ? 8'd1 : raw;
        if (r > lim) r = lim;
        return r;
    endfunction

endpackage

>>> rtl/core/tcce_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcce_step
// Next-state and result logic for one character: escape parsing, cursor
// advance, column wrap and row scroll.
// ----------------------------------------------------------------------------
module tcce_step import tcce_pkg::*; (
    input  logic [7:0]   char_byte,
    input  tcce_state_t  state_cur,
    input  logic [8:0]   cols_eff,
    input  logic [7:0]   rows_eff,
    output tcce_state_t  state_next,
    output tcce_result_t result
);

    logic        draw;
    logic        esc_next;
    logic [31:0] num_next;
    logic [8:0]  x;
    logic [8:0]  x_adv;
    logic [7:0]  y;
    logic [7:0]  y_adv;
    logic        scroll;
    logic [6:0]  row_out;

    // Decode the byte against the parser mode
    always_comb begin
        draw     = 1'b0;
        esc_next = state_cur.in_escape;
        num_next = state_cur.escape_number;
        x        = {1'b0, state_cur.cursor_column};
        y        = {1'b0, state_cur.cursor_row};
        if (!state_cur.in_escape) begin
            case (char_byte) inside
                CHAR_LF, CHAR_CR: begin
                    x = 9'd0;
                    y = y + 8'd1;
                end
                CHAR_ESC: begin
                    num_next = 32'd0;
                    esc_next = 1'b1;
                end
                default: begin
                    draw = 1'b1;
                end
            endcase
        end else begin
            case (char_byte) inside
                [CHAR_ZERO:CHAR_NINE]: begin
                    num_next = state_cur.escape_number * DEC_BASE
                             + {28'd0, char_byte[3:0]};
                end
                CHAR_D: begin
                    if (state_cur.escape_number <= {24'd0, state_cur.cursor_column}) begin
                        x = {1'b0, state_cur.cursor_column - state_cur.escape_number[7:0]};
                    end
                    esc_next = 1'b0;
                end
                CHAR_LBRACKET: begin
                    // ignored
                end
                default: begin
                    draw     = 1'b1;
                    esc_next = 1'b0;
                end
            endcase
        end
    end

    // Advance, wrap the column and scroll at the bottom row
    always_comb begin
        x_adv  = draw ? x + 9'd1 : x;
        y_adv  = y;
        scroll = 1'b0;
        if (x_adv >= cols_eff) begin
            x_adv = 9'd0;
            y_adv = y + 8'd1;
        end
        if (y_adv >= rows_eff) begin
            y_adv  = rows_eff - 8'd1;
            scroll = 1'b1;
        end
    end

    assign row_out = y[6:0];

    assign state_next.in_escape     = esc_next;
    assign state_next.escape_number = num_next;
    assign state_next.cursor_column = x_adv[7:0];
    assign state_next.cursor_row    = y_adv[6:0];

    assign result.draw_valid  = draw;
    assign result.glyph_code  = draw ? char_byte : 8'd0;
    assign result.draw_column = draw ? x[7:0] : 8'd0;
    assign result.draw_row    = draw ? row_out : 7'd0;
    assign result.scroll_up   = scroll;

endmodule

>>> rtl/core/text_console_cursor_escape_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_escape_unit
// Text cursor tracker with a small escape parser for a character console.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one character byte per transfer in s_tdata.
//   m_ channel: one result per byte. m_tuser is draw_valid; m_tdata carries
//   glyph code, draw column, draw row and the scroll flag.
//   cfg_ channel: cfg_index 0 writes text_columns, 1 writes text_rows; other
//   indexes are dropped. A write clamps the cursor into the new screen.
//   Write configuration only while no byte is in flight.
// Timing:
//   An input transfer reaches m_tvalid through the input register, where
//   the byte sits, then the output register, which the decode and cursor
//   update load once the output stage is free.
//   Throughput is one byte per cycle while m_tready is high; the cursor and
//   escape state update combinationally, so consecutive bytes never wait on each other.
// Reset:
//   aresetn low empties both registers, sets an 80 by 30 screen, puts the
//   cursor at column 0 row 0 and leaves escape mode.
// Stall:
//   With m_tready low the result holds; one more byte is taken into the
//   input register, after which s_tready drops until the result leaves.
// ----------------------------------------------------------------------------
`include "text_console_cursor_escape_unit_assert.svh"

module text_console_cursor_escape_unit import tcce_pkg::*; #(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // input bytes
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // [7:0] char_byte
    // results
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // [7:0] glyph_code, [15:8] draw_column,
                                              // [22:16] draw_row, [23] scroll_up
    output logic                   m_tuser,   // [0] draw_valid
    // configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int COL_LIMIT = (MAX_COLUMNS < HW_COL_LIMIT) ? MAX_COLUMNS : HW_COL_LIMIT;
    localparam int ROW_LIMIT = (MAX_ROWS < HW_ROW_LIMIT) ? MAX_ROWS : HW_ROW_LIMIT;
    localparam logic [8:0] COL_LIMIT_W = 9'(COL_LIMIT);
    localparam logic [7:0] ROW_LIMIT_W = 8'(ROW_LIMIT);

    logic         in_valid_reg, in_valid_next;
    logic [7:0]   in_byte_reg, in_byte_next;
    logic         out_valid_reg, out_valid_next;
    tcce_result_t out_reg, out_next;
    tcce_state_t  state_reg, state_next;
    logic [8:0]   columns_reg, columns_next;
    logic [7:0]   rows_reg, rows_next;

    logic         advance;
    logic         s_xfer;
    logic [8:0]   cols_eff;
    logic [7:0]   rows_eff;
    logic [8:0]   cols_new;
    logic [7:0]   rows_new;
    tcce_state_t  step_state;
    tcce_result_t step_result;

    // Move the held byte into the output stage when that stage frees up
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_xfer    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign cols_eff = eff_columns(columns_reg, COL_LIMIT_W);
    assign rows_eff = eff_rows(rows_reg, ROW_LIMIT_W);

    tcce_step u_step (
        .char_byte  (in_byte_reg),
        .state_cur  (state_reg),
        .cols_eff   (cols_eff),
        .rows_eff   (rows_eff),
        .state_next (step_state),
        .result     (step_result)
    );

    // Decode configuration writes
    always_comb begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_TEXT_COLUMNS: columns_next = cfg_data;
                CFG_TEXT_ROWS:    rows_next    = cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    assign cols_new = eff_columns(columns_next, COL_LIMIT_W);
    assign rows_new = eff_rows(rows_next, ROW_LIMIT_W);

    // Pick the next cursor and parser state: clamp on a write, step on advance
    always_comb begin
        state_next = state_reg;
        if (cfg_valid) begin
            if ({1'b0, state_reg.cursor_column} >= cols_new) begin
                state_next.cursor_column = 8'(cols_new - 9'd1);
            end
            if ({1'b0, state_reg.cursor_row} >= rows_new) begin
                state_next.cursor_row = 7'(rows_new - 8'd1);
            end
        end else if (advance) begin
            state_next = step_state;
        end
    end

    // Hold or load the input and output stages
    always_comb begin
        in_valid_next = in_valid_reg;
        in_byte_next  = in_byte_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
            in_byte_next  = s_tdata;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_valid_next = 1'b1;
            out_next       = step_result;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
            columns_reg   <= COLUMNS_RESET;
            rows_reg      <= ROWS_RESET;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            state_reg     <= state_next;
            columns_reg   <= columns_next;
            rows_reg      <= rows_next;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge aclk) begin
        in_byte_reg <= in_byte_next;
        out_reg     <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.draw_valid;
    assign m_tdata  = {out_reg.scroll_up, out_reg.draw_row,
                       out_reg.draw_column, out_reg.glyph_code};

    // Cursor stays inside the effective screen
    `TCCE_ALWAYS(a_column_in_range, {1'b0, state_reg.cursor_column} < cols_eff)
    `TCCE_ALWAYS(a_row_in_range, {1'b0, state_reg.cursor_row} < rows_eff)
    // A result without a glyph carries zero glyph, column and row
    `TCCE_IMPLIES(a_idle_draw_zero, out_valid_reg && !out_reg.draw_valid,
        m_tdata[22:0] == 23'd0)

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console cursor and escape unit. A
// scoreboard class tracks cursor, parser state and screen size, predicts
// the result of every byte transfer, and compares each result transfer
// field by field. Stimulus runs a short directed part and then random
// phases over a range of screen sizes, with random idle bursts on both
// sides and one long result stall that backs up the input.
// ----------------------------------------------------------------------------
module testbench;
    import tcce_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 7;
    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 250;
    localparam int REPORT_CAP   = 200;
    localparam int NUM_PHASES   = 10;
    localparam int RANDOM_SIZE  = -1;
    localparam int FLUSH_CYCLES = 8;

    // Index that maps to no register; the write must be dropped
    localparam logic [CFG_INDEX_W-1:0] CFG_NO_REGISTER = 8'hff;

    localparam int unsigned COL_CAP =
        (DEF_MAX_COLUMNS < HW_COL_LIMIT) ? DEF_MAX_COLUMNS : HW_COL_LIMIT;
    localparam int unsigned ROW_CAP =
        (DEF_MAX_ROWS < HW_ROW_LIMIT) ? DEF_MAX_ROWS : HW_ROW_LIMIT;

    // Screen size and stream length of each random phase
    localparam int PHASE_COLS [NUM_PHASES] =
        '{1, 256, 2, 0, 511, RANDOM_SIZE, 80, RANDOM_SIZE, 257, RANDOM_SIZE};
    localparam int PHASE_ROWS [NUM_PHASES] =
        '{128, 1, 0, 255, 2, RANDOM_SIZE, 129, RANDOM_SIZE, 256, RANDOM_SIZE};
    localparam int PHASE_ITEMS [NUM_PHASES] =
        '{150, 300, 100, 100, 100, 100, 100, 100, 100, 100};
    localparam int NO_NEWLINE_PHASE = 1;
    localparam int HOLD_PHASE       = 2;

    // ------------------------------------------------------------------------
    // Cursor scoreboard: predicts each result and checks the result stream
    // ------------------------------------------------------------------------
    class cursor_scoreboard;
        logic [8:0]   columns_raw;
        logic [7:0]   rows_raw;
        logic [7:0]   cur_x;
        logic [6:0]   cur_y;
        bit           escaping;
        logic [31:0]  esc_value;
        tcce_result_t expected_draws [$];
        int           errors;
        int           reports;

        function new();
            columns_raw = COLUMNS_RESET;
            rows_raw    = ROWS_RESET;
            cur_x       = '0;
            cur_y       = '0;
            escaping    = 1'b0;
            esc_value   = '0;
            errors      = 0;
            reports     = 0;
        endfunction

        function int unsigned screen_width();
            int unsigned w;
            w = 32'(columns_raw);
            if (w == 0) w = 1;
            if (w > COL_CAP) w = COL_CAP;
            return w;
        endfunction

        function int unsigned screen_height();
            int unsigned h;
            h = 32'(rows_raw);
            if (h == 0) h = 1;
            if (h > ROW_CAP) h = ROW_CAP;
            return h;
        endfunction

        // Apply a register write and pull the cursor into the new screen
        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int unsigned w, h;
            if (idx == CFG_TEXT_COLUMNS) begin
                columns_raw = data;
            end else if (idx == CFG_TEXT_ROWS) begin
                rows_raw = data[7:0];
            end else begin
                return;
            end
            w = screen_width();
            h = screen_height();
            if (cur_x >= w) cur_x = 8'(w - 1);
            if (cur_y >= h) cur_y = 7'(h - 1);
        endfunction

        // Advance the parser and cursor by one accepted byte
        function void note_byte(logic [7:0] ch);
            int unsigned  w, h, x, y;
            bit           draw, scroll;
            tcce_result_t want;
            w      = screen_width();
            h      = screen_height();
            x      = 32'(cur_x);
            y      = 32'(cur_y);
            draw   = 1'b0;
            scroll = 1'b0;
            want   = '0;
            if (!escaping) begin
                if (ch == CHAR_LF || ch == CHAR_CR) begin
                    x = 0;
                    y = y + 1;
                end else if (ch == CHAR_ESC) begin
                    esc_value = '0;
                    escaping  = 1'b1;
                end else begin
                    draw = 1'b1;
                end
            end else begin
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                    esc_value = esc_value * DEC_BASE + 32'(ch - CHAR_ZERO);
                end else if (ch == CHAR_D) begin
                    // move left only when the count fits
                    if (esc_value <= x) x = x - esc_value;
                    escaping = 1'b0;
                end else if (ch == CHAR_LBRACKET) begin
                    // bracket keeps the sequence open
                end else begin
                    draw     = 1'b1;
                    escaping = 1'b0;
                end
            end
            if (draw) begin
                want.draw_valid  = 1'b1;
                want.glyph_code  = ch;
                want.draw_column = x[7:0];
                want.draw_row    = y[6:0];
                x = x + 1;
            end
            // wrap the column, then scroll on row overflow
            if (x >= w) begin
                x = 0;
                y = y + 1;
            end
            if (y >= h) begin
                y      = h - 1;
                scroll = 1'b1;
            end
            cur_x          = x[7:0];
            cur_y          = y[6:0];
            want.scroll_up = scroll;
            expected_draws.push_back(want);
        endfunction

        function void report_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                if (reports < REPORT_CAP) begin
                    reports++;
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
                end
            end
        endfunction

        // Compare one result transfer with the oldest prediction
        function void check_result(logic [23:0] data, logic user);
            tcce_result_t want;
            if (expected_draws.size() == 0) begin
                errors++;
                if (reports < REPORT_CAP) begin
                    reports++;
                    $display("%0t: unexpected result, expected none, actual tdata %0h tuser %0b",
                             $time, data, user);
                end
                return;
            end
            want = expected_draws.pop_front();
            report_field("draw_valid",  32'(want.draw_valid),  32'(user));
            report_field("glyph_code",  32'(want.glyph_code),  32'(data[7:0]));
            report_field("draw_column", 32'(want.draw_column), 32'(data[15:8]));
            report_field("draw_row",    32'(want.draw_row),    32'(data[22:16]));
            report_field("scroll_up",   32'(want.scroll_up),   32'(data[23]));
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block under test
    // ------------------------------------------------------------------------
    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [23:0]            m_tdata;
    logic                   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    cursor_scoreboard sb = new();
    int cycle_count  = 0;
    int items_sent   = 0;
    bit quiet        = 1'b0;
    bit hold_request = 1'b0;

    text_console_cursor_escape_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Stop a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: check transfers, stall in random bursts or one long hold
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 7) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one byte, after an optional idle burst, and hold until transfer
    task automatic send_byte(logic [7:0] ch);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 7)) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(ch);
        items_sent++;
    endtask

    // Drop the input and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_register(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Send a decimal count, sometimes with a leading zero
    task automatic send_number(int unsigned value);
        logic [7:0] digits [$];
        if ($urandom_range(0, 4) == 0) send_byte(CHAR_ZERO);
        do begin
            digits.push_front(8'(CHAR_ZERO + value % 10));
            value = value / 10;
        end while (value != 0);
        foreach (digits[i]) send_byte(digits[i]);
    endtask

    // Escape sequence with optional bracket, optional random count and random terminator
    task automatic send_escape();
        int unsigned pick, ending;
        send_byte(CHAR_ESC);
        if ($urandom_range(0, 1)) send_byte(CHAR_LBRACKET);
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            send_number(32'(sb.cur_x));
        end else if (pick < 5) begin
            send_number(32'(sb.cur_x) + 1);
        end else if (pick < 8) begin
            send_number($urandom_range(0, 30));
        end else if (pick == 8) begin
            // long digit run can wrap the accumulator
            repeat ($urandom_range(8, 12)) send_byte(8'(CHAR_ZERO + $urandom_range(0, 9)));
        end
        ending = $urandom_range(0, 9);
        if (ending < 6) begin
            send_byte(CHAR_D);
        end else if (ending < 8) begin
            send_byte(8'($urandom_range(0, 255)));
        end else begin
            send_byte(CHAR_LF);
        end
    endtask

    task automatic send_text();
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(8'h20, 8'h7e)));
    endtask

    // Mix of escapes, text, line breaks and raw noise
    task automatic run_phase(int count, bit allow_newlines);
        int target;
        int unsigned pick;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                send_escape();
            end else if (pick < 70) begin
                send_text();
            end else if (pick < 82) begin
                if (allow_newlines) begin
                    send_byte($urandom_range(0, 1) ? CHAR_LF : CHAR_CR);
                end else begin
                    send_text();
                end
            end else begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int cols, rows;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: byte extremes, cursor moves, oversized move, escape ends
        send_byte(8'h00);
        send_byte(8'hff);
        send_byte("A");
        send_byte("B");
        send_byte("C");
        send_byte(CHAR_ESC);
        send_byte(CHAR_LBRACKET);
        send_byte("2");
        send_byte(CHAR_D);
        send_byte(CHAR_ESC);
        send_byte("9");
        send_byte("9");
        send_byte(CHAR_D);
        send_byte(CHAR_ESC);
        send_byte(CHAR_LF);
        send_byte(CHAR_ESC);
        send_byte(CHAR_ESC);
        send_byte(CHAR_CR);
        send_byte(CHAR_ESC);
        send_byte("1");
        send_byte("Z");
        drain_results();

        // Zero sizes count as one: every byte wraps and scrolls
        set_register(CFG_TEXT_COLUMNS, 9'd0);
        set_register(CFG_TEXT_ROWS, 9'd0);
        send_byte("a");
        send_byte(CHAR_CR);
        drain_results();

        // Oversized values clamp; unknown index is dropped
        set_register(CFG_TEXT_COLUMNS, 9'h1ff);
        set_register(CFG_TEXT_ROWS, 9'h1ff);
        set_register(CFG_NO_REGISTER, 9'($urandom_range(0, 511)));

        // Random phases over a spread of screen sizes
        for (int p = 0; p < NUM_PHASES; p++) begin
            cols = PHASE_COLS[p];
            rows = PHASE_ROWS[p];
            if (cols == RANDOM_SIZE) cols = $urandom_range(0, 1) ? $urandom_range(1, 40)
                                                               : $urandom_range(0, 511);
            if (rows == RANDOM_SIZE) rows = $urandom_range(0, 511);
            set_register(CFG_TEXT_COLUMNS, 9'(cols));
            set_register(CFG_TEXT_ROWS, 9'(rows));
            if (p == NUM_PHASES - 1) quiet = 1'b1;
            if (p == HOLD_PHASE) hold_request = 1'b1;
            run_phase(PHASE_ITEMS[p], p != NO_NEWLINE_PHASE);
            drain_results();
        end

        repeat (FLUSH_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
